// ===== design/bfd2_pkg.sv =====
// Package: widths, frame constants, tap-mode type and rounding helper for the decimator.
package bfd2_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 15;
  localparam int SUM_W    = SAMPLE_W + 4;
  localparam int QUO_W    = SUM_W - 3;

  localparam logic [POS_W-1:0] PAIRS_MIN   = POS_W'(3);
  localparam logic [POS_W-1:0] PAIRS_MAX   = POS_W'(16384);
  localparam logic [POS_W-1:0] PAIRS_RESET = POS_W'(8000);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Which taps feed the filter for the sample now being taken.
  typedef enum logic [1:0] {
    TAP_NONE,
    TAP_START,
    TAP_MID,
    TAP_LAST
  } tap_mode_t;

  // Divide by 16 rounding half away from zero, then saturate to a sample.
  function automatic sample_t round_div16(input sum_t s);
    logic signed [SUM_W:0]   t;
    logic signed [QUO_W-1:0] q;
    sample_t                 r;
    t = s[SUM_W-1] ? ($signed({s[SUM_W-1], s}) + (SUM_W+1)'(7))
                   : ($signed({s[SUM_W-1], s}) + (SUM_W+1)'(8));
    q = QUO_W'(t >>> 4);
    if (q > $signed(QUO_W'(32767))) begin
      r = sample_t'(16'sh7fff);
    end else if (q < $signed(-QUO_W'(32768))) begin
      r = sample_t'(16'sh8000);
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/binomial_fir_decimate_by_two.sv =====
// Five-tap binomial (1,4,6,4,1)/16 low-pass filter, decimating by two over clamped frames.
// A result is loaded into the output register at the clock edge that accepts its input.
// Throughput: one input sample per cycle while in_stall is low; the filter sum and
// rounding sit between the history/position and output registers, so nothing iterates.
// A new sample that yields no result is taken even while the output register is stalled.
// Reset (rst, synchronous): frame length 8000 pairs, history zero, position zero, output empty.
module binomial_fir_decimate_by_two (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_pairs_we,
  input  logic [bfd2_pkg::POS_W-1:0]    frame_pairs_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [bfd2_pkg::SAMPLE_W-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [bfd2_pkg::SAMPLE_W-1:0] sample_out,
  output logic                          frame_last
);
  import bfd2_pkg::*;

  logic [POS_W-1:0] frame_pairs;
  logic [POS_W-1:0] position;
  sample_t          history [4];

  logic [POS_W-1:0] pairs_eff;
  logic [POS_W-1:0] pairs_m1;
  logic [POS_W-1:0] last_pos;
  tap_mode_t        mode;
  logic             produce;
  logic             in_accept;
  logic             out_accept;
  sample_t          ta, tb, tc, td, te;
  sum_t             sum;
  sample_t          result;

  // Clamp frame length and derive the last position of a frame
  always_comb begin
    if (frame_pairs < PAIRS_MIN) begin
      pairs_eff = PAIRS_MIN;
    end else if (frame_pairs > PAIRS_MAX) begin
      pairs_eff = PAIRS_MAX;
    end else begin
      pairs_eff = frame_pairs;
    end
    pairs_m1 = pairs_eff - POS_W'(1);
    last_pos = {pairs_m1[POS_W-2:0], 1'b1};
  end

  // Decide which taps apply at this position
  always_comb begin
    priority if (position == last_pos) begin
      mode = TAP_LAST;
    end else if (!position[0] && position >= POS_W'(4)) begin
      mode = TAP_MID;
    end else if (position == POS_W'(2)) begin
      mode = TAP_START;
    end else begin
      mode = TAP_NONE;
    end
  end

  assign produce    = (mode != TAP_NONE);
  assign in_stall   = produce && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Select tap inputs, clamping at the frame edges
  always_comb begin
    unique case (mode)
      TAP_LAST: begin
        ta = history[2]; tb = history[1]; tc = history[0]; td = sample_in; te = sample_in;
      end
      TAP_START: begin
        ta = history[1]; tb = history[1]; tc = history[1]; td = history[0]; te = sample_in;
      end
      TAP_MID, TAP_NONE: begin
        ta = history[3]; tb = history[2]; tc = history[1]; td = history[0]; te = sample_in;
      end
      default: begin
        ta = history[3]; tb = history[2]; tc = history[1]; td = history[0]; te = sample_in;
      end
    endcase
  end

  // Weighted sum with shift-and-add taps, then round
  always_comb begin
    sum = SUM_W'(ta)
        + (SUM_W'(tb) <<< 2)
        + (SUM_W'(tc) <<< 2) + (SUM_W'(tc) <<< 1)
        + (SUM_W'(td) <<< 2)
        + SUM_W'(te);
    result = round_div16(sum);
  end

  // Hold the frame length; a write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pairs <= PAIRS_RESET;
      position    <= '0;
    end else if (frame_pairs_we) begin
      frame_pairs <= frame_pairs_wdata;
      position    <= '0;
    end else if (in_accept) begin
      if (position >= last_pos) begin
        position <= '0;
      end else begin
        position <= position + POS_W'(1);
      end
    end
  end

  // Advance the sample history, newest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        history[i] <= '0;
      end
    end else if (in_accept) begin
      history[3] <= history[2];
      history[2] <= history[1];
      history[1] <= history[0];
      history[0] <= sample_in;
    end
  end

  // Output register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && produce) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && produce) begin
      sample_out <= result;
      frame_last <= (mode == TAP_LAST);
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    position <= last_pos)
    else $error("position past end of frame");

  a_last_flagged: assert property (@(posedge clk) disable iff (rst)
    in_accept && !frame_pairs_we && position == last_pos |=> out_valid && frame_last)
    else $error("frame end transaction did not flag last output");

  a_first_unflagged: assert property (@(posedge clk) disable iff (rst)
    in_accept && !frame_pairs_we && position == POS_W'(2) |=> out_valid && !frame_last)
    else $error("first output of frame missing or flagged");

  a_no_result_keeps: assert property (@(posedge clk) disable iff (rst)
    in_accept && !produce && out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("sample without result disturbed pending output");
`endif

endmodule

// ===== tb/sv/tb_binomial_fir_decimate_by_two.sv =====
// Self-checking testbench for the five-tap binomial decimate-by-two filter.
`timescale 1ns / 100ps

module tb_binomial_fir_decimate_by_two;
  import bfd2_pkg::*;

  // One expected filter output.
  typedef struct {
    sample_t value;
    logic    last;
  } decimated_t;

  logic                clk;
  logic                rst;
  logic                frame_pairs_we;
  logic [POS_W-1:0]    frame_pairs_wdata;
  logic                in_valid;
  logic                in_stall;
  sample_t             sample_in;
  logic                out_valid;
  logic                out_stall;
  sample_t             sample_out;
  logic                frame_last;

  // Samples waiting to be driven, and filter outputs waiting to arrive.
  sample_t             pending_samples[$];
  decimated_t          filtered_q[$];

  // Predictor state: frame length register, tap history (newest first), frame position.
  logic [POS_W-1:0]    pairs_cfg;
  sample_t             tap_hist[4];
  logic [POS_W-1:0]    frame_pos;

  int                  presented_cnt = 0;
  int                  accepted_cnt  = 0;
  int                  mismatch_cnt  = 0;
  int                  cyc_count     = 0;
  int                  random_items;

  binomial_fir_decimate_by_two i_dut (
    .clk               (clk),
    .rst               (rst),
    .frame_pairs_we    (frame_pairs_we),
    .frame_pairs_wdata (frame_pairs_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .sample_in         (sample_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sample_out        (sample_out),
    .frame_last        (frame_last)
  );

  // Toggle the clock every half period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Count a mismatch and print a line for each of the first 40.
  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("mismatch at cycle %0d: %s", cyc_count, what);
    end
  endtask

  // Weighted tap sum, rounded half away from zero, saturated to a sample.
  function automatic sample_t binomial_round(input sample_t a, input sample_t b,
                                             input sample_t c, input sample_t d,
                                             input sample_t e);
    int s;
    int r;
    s = int'(a) + 4 * int'(b) + 6 * int'(c) + 4 * int'(d) + int'(e);
    if (s >= 0) begin
      r = (s + 8) / 16;
    end else begin
      r = -((-s + 8) / 16);
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return sample_t'(r);
  endfunction

  // Advance the predicted filter by one accepted sample.
  task automatic track_sample(input sample_t x);
    int         eff;
    int         last;
    int         p;
    tap_mode_t  mode;
    decimated_t r;
    eff = int'(pairs_cfg);
    if (eff < int'(PAIRS_MIN)) eff = int'(PAIRS_MIN);
    if (eff > int'(PAIRS_MAX)) eff = int'(PAIRS_MAX);
    last = 2 * eff - 1;
    p = int'(frame_pos);
    if (p == last) begin
      mode = TAP_LAST;
    end else if ((p % 2) == 0 && p >= 4) begin
      mode = TAP_MID;
    end else if (p == 2) begin
      mode = TAP_START;
    end else begin
      mode = TAP_NONE;
    end
    r.last = 1'b0;
    case (mode)
      TAP_LAST: begin
        r.value = binomial_round(tap_hist[2], tap_hist[1], tap_hist[0], x, x);
        r.last  = 1'b1;
      end
      TAP_MID: begin
        r.value = binomial_round(tap_hist[3], tap_hist[2], tap_hist[1], tap_hist[0], x);
      end
      TAP_START: begin
        // first sample of the frame fills every tap at or before the center
        r.value = binomial_round(tap_hist[1], tap_hist[1], tap_hist[1], tap_hist[0], x);
      end
      default: begin
        r.value = '0;
      end
    endcase
    if (mode != TAP_NONE) filtered_q.push_back(r);
    tap_hist[3] = tap_hist[2];
    tap_hist[2] = tap_hist[1];
    tap_hist[1] = tap_hist[0];
    tap_hist[0] = x;
    frame_pos = (p >= last) ? '0 : POS_W'(p + 1);
  endtask

  // No idling on either side during the opening stretch of each repeating window of cycles.
  function automatic bit take_break();
    return ((cyc_count % 5000) >= 900) && ($urandom_range(0, 99) < 31);
  endfunction

  // Mostly full-range samples, some extremes, some near zero.
  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: return sample_t'(16'sh7fff);
        1: return sample_t'(16'sh8000);
        2: return sample_t'(16'sh0000);
        default: return sample_t'(16'shffff);
      endcase
    end else if (r < 40) begin
      return sample_t'($urandom_range(0, 64) - 32);
    end
    return sample_t'($urandom);
  endfunction

  // Mostly short frames, now and then a clamped or arbitrary length.
  function automatic logic [POS_W-1:0] pick_pairs();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return POS_W'($urandom_range(0, 2));
    if (r < 60) return POS_W'($urandom_range(3, 12));
    if (r < 80) return POS_W'($urandom_range(13, 64));
    if (r < 90) return POS_W'($urandom);
    case ($urandom_range(0, 4))
      0: return POS_W'(3);
      1: return POS_W'(16384);
      2: return POS_W'(16385);
      3: return POS_W'(32767);
      default: return POS_W'(0);
    endcase
  endfunction

  // Wait until every sample is taken and every output has arrived, then let it settle.
  task automatic wait_drained();
    while (!(pending_samples.size() == 0 && accepted_cnt == presented_cnt &&
             filtered_q.size() == 0)) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Write the frame length while the block is idle.
  task automatic write_pairs(input logic [POS_W-1:0] v);
    wait_drained();
    frame_pairs_we    <= 1'b1;
    frame_pairs_wdata <= v;
    @(negedge clk);
    frame_pairs_we    <= 1'b0;
  endtask

  // Queue a number of random samples.
  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) pending_samples.push_back(rand_sample());
  endtask

  // Predict on every accepted transaction; check outputs first so the order holds.
  always @(posedge clk) begin
    cyc_count++;
    if (rst) begin
      pairs_cfg = PAIRS_RESET;
      tap_hist  = '{default: '0};
      frame_pos = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output %0d last %0b", sample_out, frame_last));
        end else begin
          if (sample_out !== filtered_q[0].value) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      sample_out, filtered_q[0].value));
          end
          if (frame_last !== filtered_q[0].last) begin
            report_mismatch($sformatf("frame_last %0b, expected %0b",
                                      frame_last, filtered_q[0].last));
          end
          filtered_q.delete(0);
        end
      end
      if (frame_pairs_we) begin
        pairs_cfg = frame_pairs_wdata;
        frame_pos = '0;
      end
      if (in_valid && !in_stall) begin
        track_sample(sample_in);
        accepted_cnt++;
        pending_samples.delete(0);
      end
    end
  end

  // Drive samples at the falling edge; hold a stalled transaction unchanged.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      sample_in <= '0;
    end else if (!(in_valid && accepted_cnt < presented_cnt)) begin
      if (pending_samples.size() > 0 && !take_break()) begin
        in_valid  <= 1'b1;
        sample_in <= pending_samples[0];
        presented_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= take_break();
  end

  // Stimulus and final verdict.
  initial begin
    rst               = 1'b1;
    frame_pairs_we    = 1'b0;
    frame_pairs_wdata = '0;
    random_items      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset frame length: full-scale steps.
    pending_samples.push_back(sample_t'(16'sh7fff));
    pending_samples.push_back(sample_t'(16'sh7fff));
    pending_samples.push_back(sample_t'(16'sh7fff));
    pending_samples.push_back(sample_t'(16'sh8000));
    pending_samples.push_back(sample_t'(16'sh8000));
    pending_samples.push_back(sample_t'(16'shffff));

    // Shortest frame: full-scale levels, then rounding ties in both signs.
    write_pairs(POS_W'(3));
    for (int k = 0; k < 6; k++) begin
      pending_samples.push_back((k % 2) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000));
    end
    for (int k = 0; k < 6; k++) pending_samples.push_back(sample_t'((k == 1) ? 2 : 0));
    for (int k = 0; k < 6; k++) pending_samples.push_back(sample_t'((k == 1) ? -2 : 0));

    // Zero clamps up to the minimum frame length.
    write_pairs(POS_W'(0));
    for (int k = 1; k <= 6; k++) pending_samples.push_back(sample_t'(k * 1000));

    // Random phases with a frame length write between each.
    while (random_items < 760) begin
      int n;
      n = $urandom_range(5, 60);
      write_pairs(pick_pairs());
      queue_random(n);
      random_items += n;
    end

    // A few samples at the largest length, then the clamp above it, then the reset length.
    write_pairs(POS_W'(16384));
    queue_random(20);
    write_pairs(POS_W'(32767));
    queue_random(20);
    write_pairs(PAIRS_RESET);
    queue_random(20);

    // Drain and settle.
    while (!(pending_samples.size() == 0 && accepted_cnt == presented_cnt)) begin
      @(negedge clk);
    end
    for (int k = 0; k < 2000 && filtered_q.size() != 0; k++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (filtered_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected outputs never arrived", filtered_q.size()));
    end

    if (mismatch_cnt == 0) begin
      $display("binomial_fir_decimate_by_two regression: pass");
    end else begin
      $display("binomial_fir_decimate_by_two regression: fail");
    end
    $finish;
  end

  // Bound the run.
  initial begin
    #5_000_000;
    $display("binomial_fir_decimate_by_two regression: fail");
    $finish;
  end

endmodule
